// ===== hdl/hashed_session_state_table_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the session state table.
// Each macro compiles to nothing when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef HASHED_SESSION_STATE_TABLE_TOP_MACROS_SVH
`define HASHED_SESSION_STATE_TABLE_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("same-cycle implication failed");
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("next-cycle implication failed");
`else
`define ASSERT_IMP(name, clk, rst_n, pre, post)
`define ASSERT_NXT(name, clk, rst_n, pre, post)
`endif

`endif

// ===== hdl/hsst_pkg.sv =====
// ---------------------------------------------------------------------------
// Session state table package
// Field widths, operation and status codes and defaults shared by the interfaces and modules.
// ---------------------------------------------------------------------------
package hsst_pkg;

  localparam int unsigned KEY_W    = 31;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned ST_W     = 2;

  localparam int unsigned DEF_CAPACITY = 32;
  localparam int unsigned DEF_BUCKETS  = 8;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT     = 2'd0,
    OP_CONNECT    = 2'd1,
    OP_DISCONNECT = 2'd2,
    OP_LOCK       = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    RS_OK       = 3'd0,
    RS_NOTFOUND = 3'd1,
    RS_INUSE    = 3'd2,
    RS_BLOCKED  = 3'd3,
    RS_NOTCONN  = 3'd4,
    RS_FULL     = 3'd5,
    RS_DUP      = 3'd6
  } rsp_status_e;

  typedef enum logic [ST_W-1:0] {
    ES_IDLE    = 2'd0,
    ES_INUSE   = 2'd1,
    ES_BLOCKED = 2'd2
  } entry_state_e;

endpackage

// ===== hdl/hsst_req_if.sv =====
// ---------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one table request word.
// ---------------------------------------------------------------------------
interface hsst_req_if;

  logic                          valid;
  logic                          ready;
  logic [hsst_pkg::OP_W-1:0]     req_type;
  logic [hsst_pkg::KEY_W-1:0]    account_number;

  modport source (output valid, output req_type, output account_number, input ready);
  modport sink   (input valid, input req_type, input account_number, output ready);

endinterface

// ===== hdl/hsst_rsp_if.sv =====
// ---------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one table response word.
// ---------------------------------------------------------------------------
interface hsst_rsp_if;

  logic                          valid;
  logic                          ready;
  logic [hsst_pkg::STATUS_W-1:0] status;
  logic [hsst_pkg::ST_W-1:0]     entry_state;

  modport source (output valid, output status, output entry_state, input ready);
  modport sink   (input valid, input status, input entry_state, output ready);

endinterface

// ===== hdl/hsst_hash.sv =====
// ---------------------------------------------------------------------------
// Bucket hash unit
// Reduces a key modulo BUCKETS by reciprocal multiplication; key, product and remainder are registered in turn.
// ---------------------------------------------------------------------------
module hsst_hash #(
  parameter int unsigned BUCKETS = hsst_pkg::DEF_BUCKETS,
  localparam int unsigned BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [hsst_pkg::KEY_W-1:0] key_i,
  output logic                       done_o,
  output logic [BKT_W-1:0]           bucket_o
);

  localparam int unsigned KEY_W  = hsst_pkg::KEY_W;
  localparam int unsigned LOG_W  = $clog2(BUCKETS);
  localparam int unsigned REM_W  = LOG_W + 1;
  localparam int unsigned SHIFT  = KEY_W + LOG_W;
  localparam int unsigned RCP_W  = KEY_W + 1;
  localparam int unsigned PROD_W = KEY_W + RCP_W;
  // The reciprocal fits in RCP_W bits because 2^LOG_W is below twice BUCKETS.
  localparam logic [RCP_W-1:0] RECIP = RCP_W'((64'd1 << SHIFT) / 64'(BUCKETS));

  logic              mul_vld_q, sub_vld_q, done_q;
  logic [KEY_W-1:0]  key_q;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [KEY_W-1:0]  quot;
  logic [REM_W-1:0]  rem_q, rem_d;

  // The truncated reciprocal gives a quotient that is low by at most one, so
  // the remainder stays below twice BUCKETS and one subtraction corrects it.
  assign prod_d = PROD_W'(key_q) * PROD_W'(RECIP);
  assign quot   = KEY_W'(prod_q >> SHIFT);
  assign rem_d  = REM_W'(key_q - KEY_W'(quot * KEY_W'(BUCKETS)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
      sub_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      mul_vld_q <= start_i;
      sub_vld_q <= mul_vld_q;
      done_q    <= sub_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      key_q <= key_i;
    end
    if (mul_vld_q) begin
      prod_q <= prod_d;
    end
    if (sub_vld_q) begin
      rem_q <= rem_d;
    end
  end

  assign done_o   = done_q;
  assign bucket_o = (rem_q >= REM_W'(BUCKETS)) ? BKT_W'(rem_q - REM_W'(BUCKETS))
                                               : BKT_W'(rem_q);

endmodule

// ===== hdl/hashed_session_state_table_top.sv =====
// Flow: each request is hashed, its bucket head read and its chain walked entry by entry;
// then the entry is updated or a new key is linked in, and the response word is registered.
// Requests are handled one at a time: the next is taken once the response word is loaded,
// and an earlier response word that is not yet taken holds that load off.
// Reset: all chains empty (bucket valid bits cleared at once), fill count zero;
// the block accepts requests as soon as reset is released.
// ---------------------------------------------------------------------------
// Hashed session state table
// Chained hash table of account keys with an idle, in-use or blocked status.
// ---------------------------------------------------------------------------
`include "hashed_session_state_table_top_macros.svh"

module hashed_session_state_table_top #(
  parameter int unsigned CAPACITY = hsst_pkg::DEF_CAPACITY,
  parameter int unsigned BUCKETS  = hsst_pkg::DEF_BUCKETS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hsst_req_if.sink  req_i,
  hsst_rsp_if.source rsp_o
);

  localparam int unsigned KEY_W = hsst_pkg::KEY_W;
  localparam int unsigned ST_W  = hsst_pkg::ST_W;
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned NW    = $clog2(CAPACITY + 1);
  localparam int unsigned BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned ENT_W = KEY_W + ST_W + NW;

  localparam logic [NW-1:0] NO_ENTRY = NW'(CAPACITY);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_HASH  = 8'b0000_0010,
    S_HEADW = 8'b0000_0100,
    S_WALK  = 8'b0000_1000,
    S_CHK   = 8'b0001_0000,
    S_UPD   = 8'b0010_0000,
    S_LINK  = 8'b0100_0000,
    S_RESP  = 8'b1000_0000
  } state_e;

  // Entry word: {key, status, next link}.
  logic [ENT_W-1:0] ent_mem [CAPACITY];
  logic [NW-1:0]    head_mem [BUCKETS];

  state_e                 state_q, state_d;
  logic [NW-1:0]          fill_q, fill_d;
  logic [BUCKETS-1:0]     head_valid_q, head_valid_d;
  logic                   out_valid_q, out_valid_d;

  hsst_pkg::op_e          op_q, op_d;
  logic [KEY_W-1:0]       key_q, key_d;
  logic [BKT_W-1:0]       bucket_q, bucket_d;
  logic [NW-1:0]          cur_q, cur_d;
  logic [NW-1:0]          prev_q, prev_d;
  logic [ENT_W-1:0]       prev_word_q, prev_word_d;
  logic [NW-1:0]          steps_q, steps_d;
  logic                   hit_q, hit_d;
  logic [NW-1:0]          slot_q, slot_d;
  hsst_pkg::rsp_status_e  res_status_q, res_status_d;
  hsst_pkg::entry_state_e res_state_q, res_state_d;
  logic [hsst_pkg::STATUS_W-1:0] out_status_q, out_status_d;
  logic [ST_W-1:0]        out_state_q, out_state_d;

  logic [ENT_W-1:0]       ent_rdata_q;
  logic [NW-1:0]          head_rdata_q;
  logic                   ent_rd, ent_we;
  logic [IDX_W-1:0]       ent_waddr;
  logic [ENT_W-1:0]       ent_wdata;
  logic                   head_we;
  logic                   ins_new;

  logic [KEY_W-1:0]       rd_key;
  logic [ST_W-1:0]        rd_st;
  logic [NW-1:0]          rd_next;

  logic                   hash_start, hash_done;
  logic [BKT_W-1:0]       hash_bucket;

  logic                   req_fire, rsp_fire;

  assign req_fire = req_i.valid && req_i.ready;
  assign rsp_fire = rsp_o.valid && rsp_o.ready;
  assign hash_start = req_fire;

  assign rd_key  = ent_rdata_q[ENT_W-1 -: KEY_W];
  assign rd_st   = ent_rdata_q[NW +: ST_W];
  assign rd_next = ent_rdata_q[NW-1:0];

  hsst_hash #(
    .BUCKETS (BUCKETS)
  ) u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (hash_start),
    .key_i    (req_i.account_number),
    .done_o   (hash_done),
    .bucket_o (hash_bucket)
  );

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    head_valid_d = head_valid_q;
    out_valid_d  = out_valid_q;
    op_d         = op_q;
    key_d        = key_q;
    bucket_d     = bucket_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    prev_word_d  = prev_word_q;
    steps_d      = steps_q;
    hit_d        = hit_q;
    slot_d       = slot_q;
    res_status_d = res_status_q;
    res_state_d  = res_state_q;
    out_status_d = out_status_q;
    out_state_d  = out_state_q;
    ent_rd       = 1'b0;
    ent_we       = 1'b0;
    ent_waddr    = cur_q[IDX_W-1:0];
    ent_wdata    = ent_rdata_q;
    head_we      = 1'b0;
    ins_new      = 1'b0;

    if (rsp_fire) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          op_d    = hsst_pkg::op_e'(req_i.req_type);
          key_d   = req_i.account_number;
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        // The bucket head is read as the hash completes.
        if (hash_done) begin
          bucket_d = hash_bucket;
          state_d  = S_HEADW;
        end
      end
      S_HEADW: begin
        cur_d   = head_valid_q[bucket_q] ? head_rdata_q : NO_ENTRY;
        prev_d  = NO_ENTRY;
        steps_d = '0;
        state_d = S_WALK;
      end
      S_WALK: begin
        if (cur_q >= NO_ENTRY || steps_q >= NW'(CAPACITY)) begin
          cur_d   = NO_ENTRY;
          hit_d   = 1'b0;
          state_d = S_UPD;
        end else begin
          ent_rd  = 1'b1;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (rd_key < key_q) begin
          prev_d      = cur_q;
          prev_word_d = ent_rdata_q;
          cur_d       = rd_next;
          steps_d     = steps_q + NW'(1);
          state_d     = S_WALK;
        end else begin
          hit_d   = (rd_key == key_q);
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        res_status_d = hsst_pkg::RS_OK;
        res_state_d  = hsst_pkg::ES_IDLE;
        state_d      = S_RESP;
        if (op_q == hsst_pkg::OP_INSERT) begin
          priority if (hit_q) begin
            res_status_d = hsst_pkg::RS_DUP;
            res_state_d  = hsst_pkg::entry_state_e'(rd_st);
          end else if (fill_q >= NW'(CAPACITY)) begin
            res_status_d = hsst_pkg::RS_FULL;
          end else begin
            ins_new   = 1'b1;
            ent_we    = 1'b1;
            ent_waddr = fill_q[IDX_W-1:0];
            ent_wdata = {key_q, hsst_pkg::ES_IDLE, cur_q};
            slot_d    = fill_q;
            fill_d    = fill_q + NW'(1);
            state_d   = S_LINK;
          end
        end else if (!hit_q) begin
          res_status_d = hsst_pkg::RS_NOTFOUND;
        end else begin
          res_state_d = hsst_pkg::entry_state_e'(rd_st);
          unique case (op_q)
            hsst_pkg::OP_CONNECT: begin
              unique case (rd_st)
                hsst_pkg::ES_IDLE:  res_state_d  = hsst_pkg::ES_INUSE;
                hsst_pkg::ES_INUSE: res_status_d = hsst_pkg::RS_INUSE;
                default:            res_status_d = hsst_pkg::RS_BLOCKED;
              endcase
            end
            hsst_pkg::OP_DISCONNECT: begin
              if (rd_st == hsst_pkg::ES_INUSE) begin
                res_state_d = hsst_pkg::ES_IDLE;
              end else begin
                res_status_d = hsst_pkg::RS_NOTCONN;
              end
            end
            default: begin
              unique case (rd_st)
                hsst_pkg::ES_IDLE:  res_state_d  = hsst_pkg::ES_BLOCKED;
                hsst_pkg::ES_INUSE: res_status_d = hsst_pkg::RS_INUSE;
                default:            res_status_d = hsst_pkg::RS_BLOCKED;
              endcase
            end
          endcase
          ent_we    = 1'b1;
          ent_waddr = cur_q[IDX_W-1:0];
          ent_wdata = {rd_key, res_state_d, rd_next};
        end
      end
      S_LINK: begin
        if (prev_q < NO_ENTRY) begin
          ent_we    = 1'b1;
          ent_waddr = prev_q[IDX_W-1:0];
          ent_wdata = {prev_word_q[ENT_W-1:NW], slot_q};
        end else begin
          head_we                = 1'b1;
          head_valid_d[bucket_q] = 1'b1;
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_state_d  = res_state_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fill_q       <= '0;
      head_valid_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      fill_q       <= fill_d;
      head_valid_q <= head_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    key_q        <= key_d;
    bucket_q     <= bucket_d;
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    prev_word_q  <= prev_word_d;
    steps_q      <= steps_d;
    hit_q        <= hit_d;
    slot_q       <= slot_d;
    res_status_q <= res_status_d;
    res_state_q  <= res_state_d;
    out_status_q <= out_status_d;
    out_state_q  <= out_state_d;
  end

  // Requests are handled one at a time and every write lands before the next
  // walk starts, so reads never need forwarding.
  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (ent_rd) begin
      ent_rdata_q <= ent_mem[cur_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[bucket_q] <= slot_q;
    end
    if (hash_done) begin
      head_rdata_q <= head_mem[hash_bucket];
    end
  end

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.entry_state = out_state_q;

  `ASSERT_NXT(a_accept_starts_hash, clk_i, rst_ni, req_fire, state_q == S_HASH)
  `ASSERT_NXT(a_insert_bumps_fill, clk_i, rst_ni, ins_new, fill_q == $past(fill_q) + NW'(1))
  `ASSERT_IMP(a_hit_key_matches, clk_i, rst_ni, (state_q == S_UPD) && hit_q, rd_key == key_q)
  `ASSERT_IMP(a_rsp_from_resp, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == S_RESP))

endmodule
